[src/gpseq_pkg.sv]
package gpseq_pkg;

    // Event codes carried on the input side.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_XCHG  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Sequencer modes.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_POLL = 2'd1;
    localparam logic [1:0] MODE_CFG  = 2'd2;

    // Link bytes.
    localparam logic [7:0] BYTE_START  = 8'h01;
    localparam logic [7:0] BYTE_POLL   = 8'h42;
    localparam logic [7:0] ID_ANALOG   = 8'h73;

    // Poll frame positions.
    localparam logic [4:0] POS_POLL_CMD  = 5'd1;
    localparam logic [4:0] POS_POLL_ID   = 5'd2;
    localparam logic [4:0] POS_FILLER    = 5'd3;
    localparam logic [4:0] POS_FIRST_RD  = 5'd4;
    localparam logic [4:0] POS_LAST_POLL = 5'd9;

    localparam logic [1:0] NUM_FRAMES = 2'd3;
    localparam logic [1:0] LAST_FRAME = 2'd2;
    localparam int unsigned NUM_READINGS = 6;

    // Bit offsets of the result fields within the master-side tdata.
    localparam int unsigned TX_BYTE_LSB   = 0;
    localparam int unsigned TX_REQ_BIT    = 8;
    localparam int unsigned ATTN_BIT      = 9;
    localparam int unsigned READINGS_LSB  = 10;
    localparam int unsigned DAV_BIT       = 58;
    localparam int unsigned RECONFIG_BIT  = 59;
    localparam int unsigned M_TDATA_W     = 64;

    typedef logic [7:0] byte_t;

    // Length of each configuration frame in bytes.
    function automatic logic [4:0] cfg_len(input logic [1:0] frame);
        logic [4:0] len;
        begin
            case (frame)
                2'd0:    len = 5'd5;
                2'd1:    len = 5'd9;
                2'd2:    len = 5'd9;
                default: len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // Bytes of the enter-config, set-analog and exit-config frames.
    function automatic byte_t cfg_byte(input logic [1:0] frame, input logic [3:0] pos);
        byte_t b;
        begin
            b = 8'h00;
            case (pos)
                4'd0: b = 8'h01;
                4'd1: b = (frame == 2'd1) ? 8'h44 : 8'h43;
                4'd3: b = (frame == 2'd2) ? 8'h00 : 8'h01;
                4'd4: b = (frame == 2'd1) ? 8'h03 : ((frame == 2'd2) ? 8'h5A : 8'h00);
                4'd5, 4'd6, 4'd7, 4'd8: b = (frame == 2'd2) ? 8'h5A : 8'h00;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

[src/gamepad_poll_sequencer_core.sv]
// Channel   | Ports                      | Contents
// ----------+----------------------------+---------------------------------------------
// event in  | s_tvalid/s_tready/s_t*     | tuser: op; tdata: rx_byte
// result out| m_tvalid/m_tready/m_tdata  | tx_byte, flags and the six stored readings
//
// Every accepted event produces exactly one result in the output register.
// One event is accepted per cycle; the only bound is the single output register,
// which takes a new result whenever it is empty or being drained in the same cycle.
// A stalled result holds m_tdata and blocks further events until it is taken.
// Reset (aresetn low, synchronous) returns the sequencer to idle and clears the
// readings and the data-available flag.
module gamepad_poll_sequencer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] tx_byte, [8] tx_request, [9] attention, [17:10] buttons_first,
    // [25:18] buttons_second, [33:26] right_x, [41:34] right_y, [49:42] left_x,
    // [57:50] left_y, [58] data_available, [59] reconfiguring, [63:60] zero
    output logic [63:0] m_tdata
);

    logic [1:0] mode_reg, mode_next;
    logic [4:0] pos_reg, pos_next;
    logic [1:0] frame_reg, frame_next;
    gpseq_pkg::byte_t rd_reg [gpseq_pkg::NUM_READINGS];
    gpseq_pkg::byte_t rd_next [gpseq_pkg::NUM_READINGS];
    logic       fresh_reg, fresh_next;
    logic       m_tvalid_reg;
    logic [63:0] m_tdata_reg, m_tdata_next;

    logic       accept;
    logic [1:0] op;
    gpseq_pkg::byte_t rx;
    gpseq_pkg::byte_t tx_byte;
    logic       tx_req;
    logic       attn;
    logic       dav;
    logic [4:0] rd_offset;
    logic [2:0] rd_idx;

    assign op       = s_tuser;
    assign rx       = s_tdata;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign rd_offset = pos_reg - gpseq_pkg::POS_FIRST_RD;
    assign rd_idx    = rd_offset[2:0];

    // Next state and the result of one event.
    always_comb begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        frame_next = frame_reg;
        fresh_next = fresh_reg;
        rd_next    = rd_reg;
        tx_byte    = 8'h00;
        tx_req     = 1'b0;
        case (op)
            gpseq_pkg::OP_START: begin
                mode_next  = gpseq_pkg::MODE_POLL;
                pos_next   = gpseq_pkg::POS_POLL_CMD;
                frame_next = 2'd0;
                tx_byte    = gpseq_pkg::BYTE_START;
                tx_req     = 1'b1;
            end
            gpseq_pkg::OP_XCHG: begin
                case (mode_reg)
                    gpseq_pkg::MODE_POLL: begin
                        if (pos_reg == gpseq_pkg::POS_POLL_CMD) begin
                            tx_byte  = gpseq_pkg::BYTE_POLL;
                            tx_req   = 1'b1;
                            pos_next = gpseq_pkg::POS_POLL_ID;
                        end else if (pos_reg == gpseq_pkg::POS_POLL_ID) begin
                            if (rx == gpseq_pkg::ID_ANALOG) begin
                                tx_req   = 1'b1;
                                pos_next = gpseq_pkg::POS_FILLER;
                            end else begin
                                // Wrong ID: release the device and reconfigure it,
                                // starting with a gap slot.
                                fresh_next = 1'b0;
                                mode_next  = gpseq_pkg::MODE_CFG;
                                frame_next = 2'd0;
                                pos_next   = 5'd0;
                                tx_req     = 1'b1;
                            end
                        end else if (pos_reg >= gpseq_pkg::POS_FILLER &&
                                     pos_reg <= gpseq_pkg::POS_LAST_POLL) begin
                            // Store replies: two button bytes, then inverted sticks.
                            if (pos_reg >= gpseq_pkg::POS_FIRST_RD) begin
                                rd_next[rd_idx] = (rd_idx < 3'd2) ? rx : ~rx;
                            end
                            if (pos_reg < gpseq_pkg::POS_LAST_POLL) begin
                                tx_req   = 1'b1;
                                pos_next = pos_reg + 5'd1;
                            end else begin
                                fresh_next = 1'b1;
                                mode_next  = gpseq_pkg::MODE_IDLE;
                                pos_next   = 5'd0;
                                frame_next = 2'd0;
                            end
                        end else begin
                            mode_next  = gpseq_pkg::MODE_IDLE;
                            pos_next   = 5'd0;
                            frame_next = 2'd0;
                        end
                    end
                    gpseq_pkg::MODE_CFG: begin
                        if (frame_reg < gpseq_pkg::NUM_FRAMES) begin
                            if (pos_reg < gpseq_pkg::cfg_len(frame_reg)) begin
                                tx_byte  = gpseq_pkg::cfg_byte(frame_reg, pos_reg[3:0]);
                                tx_req   = 1'b1;
                                pos_next = pos_reg + 5'd1;
                            end else if (frame_reg < gpseq_pkg::LAST_FRAME) begin
                                // Gap slot between frames lets attention rise.
                                frame_next = frame_reg + 2'd1;
                                pos_next   = 5'd0;
                                tx_req     = 1'b1;
                            end else begin
                                mode_next  = gpseq_pkg::MODE_IDLE;
                                pos_next   = 5'd0;
                                frame_next = 2'd0;
                            end
                        end else begin
                            mode_next  = gpseq_pkg::MODE_IDLE;
                            pos_next   = 5'd0;
                            frame_next = 2'd0;
                        end
                    end
                    default: begin
                        mode_next  = gpseq_pkg::MODE_IDLE;
                        pos_next   = 5'd0;
                        frame_next = 2'd0;
                    end
                endcase
            end
            gpseq_pkg::OP_READ: begin
                fresh_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Result fields that follow from the updated state.
    always_comb begin
        attn = !((mode_next == gpseq_pkg::MODE_POLL) ||
                 (mode_next == gpseq_pkg::MODE_CFG && pos_next != 5'd0));
        dav  = (op == gpseq_pkg::OP_READ) ? fresh_reg : fresh_next;
        m_tdata_next = '0;
        m_tdata_next[gpseq_pkg::TX_BYTE_LSB +: 8] = tx_byte;
        m_tdata_next[gpseq_pkg::TX_REQ_BIT]       = tx_req;
        m_tdata_next[gpseq_pkg::ATTN_BIT]         = attn;
        for (int i = 0; i < gpseq_pkg::NUM_READINGS; i++) begin
            m_tdata_next[gpseq_pkg::READINGS_LSB + 8 * i +: 8] = rd_next[i];
        end
        m_tdata_next[gpseq_pkg::DAV_BIT]      = dav;
        m_tdata_next[gpseq_pkg::RECONFIG_BIT] = (mode_next == gpseq_pkg::MODE_CFG);
    end

    // Sequencer state, updated once per accepted transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= gpseq_pkg::MODE_IDLE;
            pos_reg   <= 5'd0;
            frame_reg <= 2'd0;
            fresh_reg <= 1'b0;
            for (int i = 0; i < gpseq_pkg::NUM_READINGS; i++) begin
                rd_reg[i] <= 8'h00;
            end
        end else if (accept) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            frame_reg <= frame_next;
            fresh_reg <= fresh_next;
            rd_reg    <= rd_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

[src/gpseq_checker.sv]
module gpseq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // A stalled result keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result changed");

    // Every accepted event yields a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("Accepted event produced no result");

    // A start request selects the device and sends the start byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == gpseq_pkg::OP_START |=>
            m_tdata[7:0] == gpseq_pkg::BYTE_START && m_tdata[gpseq_pkg::TX_REQ_BIT] &&
            !m_tdata[gpseq_pkg::ATTN_BIT])
        else $error("Start request result is wrong");

    // Without an exchange request the transmit byte is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[gpseq_pkg::TX_REQ_BIT] |-> m_tdata[7:0] == 8'h00)
        else $error("Transmit byte set without a request");

    // Fresh readings never coexist with reconfiguration.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[gpseq_pkg::RECONFIG_BIT] |-> !m_tdata[gpseq_pkg::DAV_BIT])
        else $error("Data available while reconfiguring");

endmodule

bind gamepad_poll_sequencer_core gpseq_checker u_gpseq_checker (.*);

[test/gpseq_result_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the gamepad poll sequencer. It keeps its own copy of the
// sequencer state and predicts one result for every event transfer. It then
// compares each result transfer field by field with the oldest prediction.
module gpseq_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] tx_byte, [8] tx_request, [9] attention, [57:10] six readings,
    // [58] data_available, [59] reconfiguring, [63:60] zero
    input  logic [63:0] m_tdata,
    output int          mismatches,
    output int          compared,
    output int          outstanding
);

    // Enter-config, set-analog and exit-config frames, first byte first.
    localparam logic [0:2][0:8][7:0] CFG_BYTES = {
        8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A
    };
    localparam logic [0:2][4:0] CFG_LENGTHS = {5'd5, 5'd9, 5'd9};

    typedef struct packed {
        gpseq_pkg::byte_t tx_byte;
        logic             tx_request;
        logic             attention;
        logic [5:0][7:0]  readings;
        logic             data_available;
        logic             reconfiguring;
    } link_result_t;

    // Shadow copy of the sequencer state.
    logic [1:0]      seq_mode;
    logic [4:0]      seq_pos;
    logic [1:0]      seq_frame;
    logic [5:0][7:0] stored;
    logic            fresh;

    link_result_t    expected_results[$];
    link_result_t    want;
    link_result_t    next_result;

    // Returns the sequencer to idle without touching the readings.
    task automatic drop_to_idle();
        seq_mode  = gpseq_pkg::MODE_IDLE;
        seq_pos   = '0;
        seq_frame = '0;
    endtask

    // Advances the shadow state by one event and builds the result it causes.
    task automatic step_sequencer(input logic [1:0] op, input gpseq_pkg::byte_t rx,
                                  output link_result_t res);
        int k;
        res = '0;
        case (op)
            gpseq_pkg::OP_START: begin
                seq_mode       = gpseq_pkg::MODE_POLL;
                seq_pos        = gpseq_pkg::POS_POLL_CMD;
                seq_frame      = '0;
                res.tx_byte    = gpseq_pkg::BYTE_START;
                res.tx_request = 1'b1;
            end
            gpseq_pkg::OP_XCHG: begin
                if (seq_mode == gpseq_pkg::MODE_POLL) begin
                    if (seq_pos == gpseq_pkg::POS_POLL_CMD) begin
                        res.tx_byte    = gpseq_pkg::BYTE_POLL;
                        res.tx_request = 1'b1;
                        seq_pos        = gpseq_pkg::POS_POLL_ID;
                    end else if (seq_pos == gpseq_pkg::POS_POLL_ID) begin
                        res.tx_request = 1'b1;
                        if (rx == gpseq_pkg::ID_ANALOG) begin
                            seq_pos = gpseq_pkg::POS_FILLER;
                        end else begin
                            // A digital pad is switched to analog mode; the first
                            // result is the gap slot before the first frame.
                            fresh     = 1'b0;
                            seq_mode  = gpseq_pkg::MODE_CFG;
                            seq_frame = '0;
                            seq_pos   = '0;
                        end
                    end else if (seq_pos >= gpseq_pkg::POS_FILLER &&
                                 seq_pos <= gpseq_pkg::POS_LAST_POLL) begin
                        if (seq_pos >= gpseq_pkg::POS_FIRST_RD) begin
                            k = int'(seq_pos - gpseq_pkg::POS_FIRST_RD);
                            stored[k] = (k < 2) ? rx : 8'd255 - rx;
                        end
                        if (seq_pos < gpseq_pkg::POS_LAST_POLL) begin
                            res.tx_request = 1'b1;
                            seq_pos        = seq_pos + 5'd1;
                        end else begin
                            fresh = 1'b1;
                            drop_to_idle();
                        end
                    end else begin
                        drop_to_idle();
                    end
                end else if (seq_mode == gpseq_pkg::MODE_CFG &&
                             seq_frame < gpseq_pkg::NUM_FRAMES) begin
                    if (seq_pos < CFG_LENGTHS[seq_frame]) begin
                        res.tx_byte    = CFG_BYTES[seq_frame][seq_pos[3:0]];
                        res.tx_request = 1'b1;
                        seq_pos        = seq_pos + 5'd1;
                    end else if (seq_frame < gpseq_pkg::LAST_FRAME) begin
                        // Gap slot: attention goes high between two frames.
                        seq_frame      = seq_frame + 2'd1;
                        seq_pos        = '0;
                        res.tx_request = 1'b1;
                    end else begin
                        drop_to_idle();
                    end
                end else begin
                    drop_to_idle();
                end
            end
            default: ;
        endcase

        // A read reports whether the returned readings were fresh, then clears the flag.
        res.data_available = fresh;
        if (op == gpseq_pkg::OP_READ) begin
            fresh = 1'b0;
        end

        res.attention     = !(seq_mode == gpseq_pkg::MODE_POLL ||
                              (seq_mode == gpseq_pkg::MODE_CFG && seq_pos != '0));
        res.reconfiguring = (seq_mode == gpseq_pkg::MODE_CFG);
        res.readings      = stored;
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // The result side is handled before the event side: a result never belongs to
    // the event accepted at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            drop_to_idle();
            stored = '0;
            fresh  = 1'b0;
            expected_results.delete();
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no event waiting for it: tdata 0x%h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("tx_byte", want.tx_byte,
                                m_tdata[gpseq_pkg::TX_BYTE_LSB +: 8]);
                    check_field("tx_request", want.tx_request,
                                m_tdata[gpseq_pkg::TX_REQ_BIT]);
                    check_field("attention", want.attention,
                                m_tdata[gpseq_pkg::ATTN_BIT]);
                    check_field("buttons_first", want.readings[0],
                                m_tdata[gpseq_pkg::READINGS_LSB +: 8]);
                    check_field("buttons_second", want.readings[1],
                                m_tdata[gpseq_pkg::READINGS_LSB + 8 +: 8]);
                    check_field("right_x", want.readings[2],
                                m_tdata[gpseq_pkg::READINGS_LSB + 16 +: 8]);
                    check_field("right_y", want.readings[3],
                                m_tdata[gpseq_pkg::READINGS_LSB + 24 +: 8]);
                    check_field("left_x", want.readings[4],
                                m_tdata[gpseq_pkg::READINGS_LSB + 32 +: 8]);
                    check_field("left_y", want.readings[5],
                                m_tdata[gpseq_pkg::READINGS_LSB + 40 +: 8]);
                    check_field("data_available", want.data_available,
                                m_tdata[gpseq_pkg::DAV_BIT]);
                    check_field("reconfiguring", want.reconfiguring,
                                m_tdata[gpseq_pkg::RECONFIG_BIT]);
                    check_field("tdata padding", 0,
                                m_tdata[gpseq_pkg::M_TDATA_W-1:gpseq_pkg::RECONFIG_BIT+1]);
                    compared++;
                end
            end
            if (s_tvalid && s_tready) begin
                step_sequencer(s_tuser, s_tdata, next_result);
                expected_results.push_back(next_result);
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

    // The fourth op code has no function in the sequencer.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_EVENTS = 1000;
    localparam int HOLD_CYCLES   = 80;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int POLL_EVENTS   = 10;   // start plus nine exchanges
    localparam int CONFIG_EVENTS = 29;   // start, two exchanges, three frames with gaps

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] rx_byte
    logic [1:0]  s_tuser  = '0;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] tx_byte, [8] tx_request, [9] attention, [57:10] six readings,
    // [58] data_available, [59] reconfiguring, [63:60] zero
    logic [63:0] m_tdata;

    int mismatches;
    int compared;
    int outstanding;

    bit idling_on = 1'b1;
    bit hold_request = 1'b0;
    int event_count = 0;
    int analog_polls = 0;
    int config_runs = 0;
    int read_count = 0;
    int quiet_cycles = 0;

    gamepad_poll_sequencer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    gpseq_result_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .compared    (compared),
        .outstanding (outstanding)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result side: random backpressure, or one long hold-off when asked for.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= !(idling_on && $urandom_range(99) < 24);
            end
        end
    end

    // Ends the run when neither channel has moved a transfer for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles.", QUIET_LIMIT);
            $display("** gamepad_poll_sequencer_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one event, with random gaps in front, and returns after its transfer.
    task automatic send_event(input logic [1:0] op, input gpseq_pkg::byte_t rx);
        while (idling_on && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        event_count++;
        if (op == gpseq_pkg::OP_READ) begin
            read_count++;
        end
    endtask

    // Holds the input idle until every predicted result has been taken.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // One poll with random replies; the pad answers with the analog ID or with
    // another ID that triggers the configuration frames. A nonzero cut_at aborts
    // the sequence after that many events, counting the start. Reads are slipped in now and then.
    task automatic run_poll(input bit analog, input int cut_at);
        gpseq_pkg::byte_t id;
        int    total;
        int    i;
        if (analog) begin
            id = gpseq_pkg::ID_ANALOG;
            total = POLL_EVENTS;
            analog_polls++;
        end else begin
            do id = gpseq_pkg::byte_t'($urandom); while (id == gpseq_pkg::ID_ANALOG);
            total = CONFIG_EVENTS;
            config_runs++;
        end
        send_event(gpseq_pkg::OP_START, gpseq_pkg::byte_t'($urandom));
        for (i = 1; i < total && i != cut_at; i++) begin
            if ($urandom_range(99) < 4) begin
                send_event(gpseq_pkg::OP_READ, gpseq_pkg::byte_t'($urandom));
            end
            send_event(gpseq_pkg::OP_XCHG, (i == 2) ? id : gpseq_pkg::byte_t'($urandom));
        end
    endtask

    initial begin
        bit held;
        bit drained;
        int pick;
        held = 1'b0;
        drained = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reads and stray events on a freshly reset sequencer.
        send_event(gpseq_pkg::OP_READ, 8'h00);
        send_event(gpseq_pkg::OP_XCHG, 8'hFF);
        send_event(OP_UNUSED, 8'hA5);

        // Analog poll with extreme stick and button values and a read in the middle.
        send_event(gpseq_pkg::OP_START, 8'hFF);
        send_event(gpseq_pkg::OP_XCHG, 8'hFF);
        send_event(gpseq_pkg::OP_XCHG, gpseq_pkg::ID_ANALOG);
        send_event(gpseq_pkg::OP_XCHG, 8'h5A);
        send_event(gpseq_pkg::OP_XCHG, 8'h00);
        send_event(gpseq_pkg::OP_XCHG, 8'hFF);
        send_event(gpseq_pkg::OP_READ, 8'h00);
        send_event(gpseq_pkg::OP_XCHG, 8'h00);
        send_event(gpseq_pkg::OP_XCHG, 8'hFF);
        send_event(gpseq_pkg::OP_XCHG, 8'h80);
        send_event(gpseq_pkg::OP_XCHG, 8'h7F);
        send_event(gpseq_pkg::OP_READ, 8'hFF);

        // A start in the middle of a poll, then a wrong ID and a start that cuts
        // the configuration frames short.
        send_event(gpseq_pkg::OP_START, 8'h00);
        send_event(gpseq_pkg::OP_XCHG, 8'hFF);
        send_event(gpseq_pkg::OP_START, 8'h00);
        send_event(gpseq_pkg::OP_XCHG, 8'hFF);
        send_event(gpseq_pkg::OP_XCHG, 8'h41);
        send_event(gpseq_pkg::OP_XCHG, 8'h73);
        send_event(gpseq_pkg::OP_XCHG, 8'hF3);
        send_event(gpseq_pkg::OP_START, 8'h00);
        send_event(OP_UNUSED, 8'h5A);
        wait_for_drain();

        // Mostly well-formed sequences, some of them cut short, plus noise.
        event_count = 0;
        read_count = 0;
        analog_polls = 0;
        config_runs = 0;
        while (event_count < RANDOM_EVENTS) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                run_poll(1'b1, ($urandom_range(9) == 0) ? $urandom_range(1, 9) : 0);
            end else if (pick < 67) begin
                run_poll(1'b0, ($urandom_range(9) == 0) ? $urandom_range(1, 28) : 0);
            end else if (pick < 80) begin
                send_event(gpseq_pkg::OP_READ, gpseq_pkg::byte_t'($urandom));
            end else begin
                send_event(2'($urandom_range(3)), gpseq_pkg::byte_t'($urandom));
            end

            // Long output hold while the input keeps offering events.
            if (event_count >= 300 && !held) begin
                hold_request = 1'b1;
                held = 1'b1;
            end
            // A full drain with the input paused.
            if (event_count >= 450 && !drained) begin
                wait_for_drain();
                drained = 1'b1;
            end
            idling_on = !(event_count >= 600 && event_count < 750);
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Random part: %0d events, %0d analog polls, %0d configuration runs, %0d reads.",
                 event_count, analog_polls, config_runs, read_count);
        $display("Results compared: %0d, with one long output hold and one full drain.",
                 compared);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** gamepad_poll_sequencer_core: PASSED **");
        end else begin
            $display("** gamepad_poll_sequencer_core: FAILED **");
        end
        $finish;
    end

endmodule
